### sv/aes_pkg.sv
// Shared types, constants and GF/S-box functions for the AES-CBC block cipher.
package aes_pkg;

	localparam int RK_WORDS = 60;
	localparam int RK_AW = 6;
	localparam int PADDR_W = 6;

	localparam logic [2:0] REG_KEY0 = 3'd0;
	localparam logic [2:0] REG_KEY1 = 3'd1;
	localparam logic [2:0] REG_KEY2 = 3'd2;
	localparam logic [2:0] REG_KEY3 = 3'd3;
	localparam logic [2:0] REG_IVH = 3'd4;
	localparam logic [2:0] REG_IVL = 3'd5;
	localparam logic [2:0] REG_LONG = 3'd6;
	localparam logic [2:0] REG_DIR = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic exp_init;
		logic exp_step;
		logic cv_load;
		logic blk_load;
		logic rnd_init;
		logic rnd_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic exp_done;
		logic rnd_done;
		logic out_busy;
	} sts_t;

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] t;
		p = 8'h00;
		t = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ t;
			t = xt(t);
		end
		return p;
	endfunction

	function automatic logic [7:0] ginv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] p;
		r = 8'h01;
		p = x;
		for (int i = 0; i < 7; i++) begin
			p = gmul(p, p);
			r = gmul(r, p);
		end
		return (x == 8'h00) ? 8'h00 : r;
	endfunction

	function automatic logic [7:0] rl(input logic [7:0] v, input int n);
		return 8'((v << n) | (v >> (8 - n)));
	endfunction

	function automatic logic [7:0] sbox_calc(input logic [7:0] x);
		logic [7:0] b;
		b = ginv(x);
		return b ^ rl(b, 1) ^ rl(b, 2) ^ rl(b, 3) ^ rl(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] isbox_calc(input logic [7:0] y);
		return ginv(rl(y, 1) ^ rl(y, 3) ^ rl(y, 6) ^ 8'h05);
	endfunction

	typedef logic [7:0] tab_t [256];

	function automatic tab_t mk_fwd();
		tab_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
		return t;
	endfunction

	function automatic tab_t mk_inv();
		tab_t t;
		for (int i = 0; i < 256; i++) t[i] = isbox_calc(8'(i));
		return t;
	endfunction

	localparam tab_t SBOX = mk_fwd();
	localparam tab_t ISBOX = mk_inv();

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

endpackage

### sv/aes_ctrl.sv
// Controller state machine: key expansion, block load, round iteration, output.
module aes_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid,
	output logic           ready,
	input  logic           message_start,
	input  aes_pkg::sts_t  sts,
	output aes_pkg::cmd_t  cmd
);

	aes_pkg::state_t state_q, state_d;
	logic keys_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			keys_ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exp_init) keys_ready_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		ready = 1'b0;
		case (state_q)
			aes_pkg::ST_IDLE: begin
				ready = 1'b1;
				if (valid) begin
					cmd.blk_load = 1'b1;
					if (message_start || !keys_ready_q) begin
						cmd.exp_init = 1'b1;
						state_d = aes_pkg::ST_EXPAND;
					end else begin
						state_d = aes_pkg::ST_LOAD;
					end
				end
			end
			aes_pkg::ST_EXPAND: begin
				cmd.exp_step = 1'b1;
				if (sts.exp_done) begin
					cmd.cv_load = 1'b1;
					state_d = aes_pkg::ST_LOAD;
				end
			end
			aes_pkg::ST_LOAD: begin
				cmd.rnd_init = 1'b1;
				state_d = aes_pkg::ST_ROUND;
			end
			aes_pkg::ST_ROUND: begin
				cmd.rnd_step = 1'b1;
				if (sts.rnd_done) state_d = aes_pkg::ST_DONE;
			end
			aes_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d = aes_pkg::ST_IDLE;
				end
			end
			default: state_d = aes_pkg::ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> state_q == aes_pkg::ST_IDLE)
		else $error("ready outside idle");
	a_first_expand: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && ready && !keys_ready_q) |=> state_q == aes_pkg::ST_EXPAND)
		else $error("first transaction did not expand key");
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.out_busy)
		else $error("finish while output busy");
`endif

endmodule

### sv/aes_dp.sv
// Datapath: config registers, key expansion, round-key memory, round unit, CBC, output.
module aes_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [aes_pkg::PADDR_W-1:0]   paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	input  logic [63:0]                   block_high,
	input  logic [63:0]                   block_low,
	output logic [63:0]                   result_high,
	output logic [63:0]                   result_low,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  aes_pkg::cmd_t                 cmd,
	output aes_pkg::sts_t                 sts
);

	logic [63:0] key_q [4];
	logic [63:0] ivh_q, ivl_q;
	logic long_q, dir_q;
	logic [2:0] ridx;
	assign ridx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			ivh_q <= '0;
			ivl_q <= '0;
			long_q <= 1'b0;
			dir_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				aes_pkg::REG_KEY0: key_q[0] <= pwdata;
				aes_pkg::REG_KEY1: key_q[1] <= pwdata;
				aes_pkg::REG_KEY2: key_q[2] <= pwdata;
				aes_pkg::REG_KEY3: key_q[3] <= pwdata;
				aes_pkg::REG_IVH: ivh_q <= pwdata;
				aes_pkg::REG_IVL: ivl_q <= pwdata;
				aes_pkg::REG_LONG: long_q <= pwdata[0];
				aes_pkg::REG_DIR: dir_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			aes_pkg::REG_KEY0: prdata = key_q[0];
			aes_pkg::REG_KEY1: prdata = key_q[1];
			aes_pkg::REG_KEY2: prdata = key_q[2];
			aes_pkg::REG_KEY3: prdata = key_q[3];
			aes_pkg::REG_IVH: prdata = ivh_q;
			aes_pkg::REG_IVL: prdata = ivl_q;
			aes_pkg::REG_LONG: prdata = {63'd0, long_q};
			aes_pkg::REG_DIR: prdata = {63'd0, dir_q};
			default: prdata = '0;
		endcase
	end

	// key expansion: one word per cycle, sliding window of the last four or eight words
	logic [31:0] win_q [8];
	logic [5:0] wi_q;
	logic [2:0] kc_q;
	logic [7:0] rc_q;
	logic nk8_q;
	logic [3:0] nr_q;
	logic [31:0] prev, tmix, wnew;
	logic [5:0] total;

	assign total = nk8_q ? 6'd60 : 6'd44;
	assign prev = nk8_q ? win_q[7] : win_q[3];

	always_comb begin
		tmix = prev;
		if (kc_q == 3'd0)
			tmix = aes_pkg::sub_word({prev[23:0], prev[31:24]}) ^ {rc_q, 24'd0};
		else if (nk8_q && kc_q == 3'd4)
			tmix = aes_pkg::sub_word(prev);
		wnew = win_q[0] ^ tmix;
	end

	logic [31:0] rk_mem [aes_pkg::RK_WORDS];
	logic rk_we;
	logic [aes_pkg::RK_AW-1:0] rk_wa;
	logic [31:0] rk_wd;
	logic [aes_pkg::RK_AW-1:0] rk_ra;
	logic [31:0] rk_rd;

	assign sts.exp_done = (wi_q == total);
	assign rk_we = cmd.exp_step && !sts.exp_done;
	assign rk_wa = wi_q;
	assign rk_wd = (wi_q < (nk8_q ? 6'd8 : 6'd4)) ? win_q[wi_q[2:0]] : wnew;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q <= '0;
			kc_q <= '0;
			rc_q <= 8'h01;
			nk8_q <= 1'b0;
			nr_q <= 4'd10;
		end else if (cmd.exp_init) begin
			wi_q <= '0;
			kc_q <= '0;
			rc_q <= 8'h01;
			nk8_q <= long_q;
			nr_q <= long_q ? 4'd14 : 4'd10;
		end else if (rk_we) begin
			wi_q <= wi_q + 6'd1;
			if (wi_q >= (nk8_q ? 6'd8 : 6'd4)) begin
				kc_q <= (kc_q == (nk8_q ? 3'd7 : 3'd3)) ? 3'd0 : kc_q + 3'd1;
				if (wi_q >= (nk8_q ? 6'd8 : 6'd4) && kc_q == 3'd0)
					rc_q <= aes_pkg::xt(rc_q);
			end
		end
	end

	// window holds key words first; after the initial words, it shifts in new words
	always_ff @(posedge clk) begin
		if (cmd.exp_init) begin
			if (long_q) begin
				for (int i = 0; i < 4; i++) begin
					win_q[2*i] <= key_q[i][63:32];
					win_q[2*i+1] <= key_q[i][31:0];
				end
			end else begin
				win_q[0] <= key_q[0][63:32];
				win_q[1] <= key_q[0][31:0];
				win_q[2] <= key_q[1][63:32];
				win_q[3] <= key_q[1][31:0];
				for (int i = 4; i < 8; i++) win_q[i] <= key_q[i-4][31:0];
			end
		end else if (rk_we && wi_q >= (nk8_q ? 6'd8 : 6'd4)) begin
			if (nk8_q) begin
				for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
				win_q[7] <= wnew;
			end else begin
				for (int i = 0; i < 3; i++) win_q[i] <= win_q[i+1];
				win_q[3] <= wnew;
			end
		end
	end

	// round unit: rounds applied in turn, four key words read serially ahead of each round
	logic [127:0] st_q;
	logic [127:0] blk_q;
	logic [127:0] cv_q;
	logic [3:0] rnd_q;
	logic [127:0] rk_q;
	logic [1:0] kw_q;
	logic enc_q;

	always_ff @(posedge clk) begin
		if (rk_we) rk_mem[rk_wa] <= rk_wd;
		rk_rd <= rk_mem[rk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_q <= '0;
		else if (cmd.cv_load) cv_q <= {ivh_q, ivl_q};
		else if (cmd.finish) cv_q <= enc_q ? st_q : blk_q;
	end

	function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [127:0] o;
		for (int k = 0; k < 16; k++) b[k] = s[127-8*k -: 8];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (!inv) t[r+4*c] = aes_pkg::SBOX[b[r+4*((c+r)%4)]];
				else t[r+4*((c+r)%4)] = aes_pkg::ISBOX[b[r+4*c]];
			end
		for (int k = 0; k < 16; k++) o[127-8*k -: 8] = t[k];
		return o;
	endfunction

	function automatic logic [127:0] mixc(input logic [127:0] s, input logic inv);
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] o;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127-32*c -: 8];
			a1 = s[119-32*c -: 8];
			a2 = s[111-32*c -: 8];
			a3 = s[103-32*c -: 8];
			if (!inv) begin
				o[127-32*c -: 8] = aes_pkg::xt(a0) ^ aes_pkg::xt(a1) ^ a1 ^ a2 ^ a3;
				o[119-32*c -: 8] = a0 ^ aes_pkg::xt(a1) ^ aes_pkg::xt(a2) ^ a2 ^ a3;
				o[111-32*c -: 8] = a0 ^ a1 ^ aes_pkg::xt(a2) ^ aes_pkg::xt(a3) ^ a3;
				o[103-32*c -: 8] = aes_pkg::xt(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xt(a3);
			end else begin
				o[127-32*c -: 8] = aes_pkg::gmul(a0, 8'h0e) ^ aes_pkg::gmul(a1, 8'h0b)
					^ aes_pkg::gmul(a2, 8'h0d) ^ aes_pkg::gmul(a3, 8'h09);
				o[119-32*c -: 8] = aes_pkg::gmul(a0, 8'h09) ^ aes_pkg::gmul(a1, 8'h0e)
					^ aes_pkg::gmul(a2, 8'h0b) ^ aes_pkg::gmul(a3, 8'h0d);
				o[111-32*c -: 8] = aes_pkg::gmul(a0, 8'h0d) ^ aes_pkg::gmul(a1, 8'h09)
					^ aes_pkg::gmul(a2, 8'h0e) ^ aes_pkg::gmul(a3, 8'h0b);
				o[103-32*c -: 8] = aes_pkg::gmul(a0, 8'h0b) ^ aes_pkg::gmul(a1, 8'h0d)
					^ aes_pkg::gmul(a2, 8'h09) ^ aes_pkg::gmul(a3, 8'h0e);
			end
		end
		return o;
	endfunction

	// Round sequencing: a key fetch phase per round (phases 0..3 read words,
	// the round applies in phase 4, after the last word).
	logic [2:0] ph_q;
	logic [3:0] kr;
	logic [127:0] kfull;
	logic [127:0] rnd_out;
	logic last_rnd;

	assign kr = enc_q ? rnd_q : nr_q - rnd_q;
	assign rk_ra = 6'({kr, 2'b00}) + 6'(ph_q[1:0]);
	assign kfull = {rk_q[95:0], rk_rd};
	assign last_rnd = (rnd_q == nr_q);

	always_comb begin
		if (rnd_q == 4'd0)
			rnd_out = st_q ^ kfull;
		else if (enc_q)
			rnd_out = last_rnd ? sub_shift(st_q, 1'b0) ^ kfull
				: mixc(sub_shift(st_q, 1'b0), 1'b0) ^ kfull;
		else
			rnd_out = last_rnd ? sub_shift(st_q, 1'b1) ^ kfull
				: mixc(sub_shift(st_q, 1'b1) ^ kfull, 1'b1);
	end

	assign sts.rnd_done = cmd.rnd_step && ph_q == 3'd4 && last_rnd;

	always_ff @(posedge clk) begin
		if (cmd.blk_load) blk_q <= {block_high, block_low};
		if (cmd.rnd_init) begin
			enc_q <= !dir_q;
			st_q <= dir_q ? blk_q : blk_q ^ cv_q;
			rnd_q <= '0;
			ph_q <= '0;
		end else if (cmd.rnd_step) begin
			if (ph_q == 3'd4) begin
				st_q <= rnd_out;
				rnd_q <= rnd_q + 4'd1;
				ph_q <= '0;
			end else begin
				ph_q <= ph_q + 3'd1;
				if (ph_q != 3'd0) rk_q <= {rk_q[95:0], rk_rd};
			end
		end
	end

	// output register
	logic ov_q;
	logic [127:0] res_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.finish) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.finish) res_q <= enc_q ? st_q : st_q ^ cv_q;
	end
	assign out_valid = ov_q;
	assign sts.out_busy = ov_q && !out_ready;
	assign result_high = res_q[127:64];
	assign result_low = res_q[63:0];

`ifndef SYNTHESIS
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(ov_q && !out_ready))
		else $error("result overwritten");
	a_exp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wi_q <= 6'd60)
		else $error("expansion index out of range");
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rnd_step |-> rnd_q <= nr_q)
		else $error("round count overrun");
`endif

endmodule

### sv/aes_cbc_block_cipher.sv
// Top level of the AES-128/256 CBC block cipher.
// Usage:
//  - Input channel: block_high, block_low, message_start with valid/ready.
//  - Output channel: result_high, result_low with out_valid/out_ready.
//  - APB port sets key, IV, key length and direction; 64-bit registers at 8*i.
//    Write only while no transaction is in flight.
//  - A transaction with message_start, or the first one after reset, expands
//    the key (one word a cycle) and reloads the IV.
//  - Each round is four reads of the round-key memory (one port) and one round
//    step. A block runs Nr+1 rounds (including the initial key addition), plus
//    key expansion on a start.
//  - One block is in flight at a time; ready is high only while idle, so a new
//    transaction is accepted only after the previous one has finished.
//  - The result sits in an output register; if the receiver stalls, the
//    next block is accepted and computed but waits to finish until it drains.
//  - Reset clears config registers, chaining value and controller state; the round-key
//    memory holds no reset value and is refilled on the first transaction.
module aes_cbc_block_cipher (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aes_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        valid,
	output logic                        ready,
	input  logic [63:0]                 block_high,
	input  logic [63:0]                 block_low,
	input  logic                        message_start,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [63:0]                 result_high,
	output logic [63:0]                 result_low
);

	aes_pkg::cmd_t cmd;
	aes_pkg::sts_t sts;

	assign pready = 1'b1;

	aes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.message_start(message_start), .sts(sts), .cmd(cmd)
	);

	aes_dp u_dp (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.block_high(block_high), .block_low(block_low),
		.result_high(result_high), .result_low(result_low),
		.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
	);

endmodule

### bench/aes_cbc_checker.sv
// Checker for the AES-CBC block cipher: config shadow, CBC prediction, result compare.
`timescale 1ns / 100ps
module aes_cbc_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aes_pkg::PADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	input  logic                        pready,
	input  logic                        valid,
	input  logic                        ready,
	input  logic [63:0]                 block_high,
	input  logic [63:0]                 block_low,
	input  logic                        message_start,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [63:0]                 result_high,
	input  logic [63:0]                 result_low,
	output int                          errors,
	output int                          pending
);

	logic [63:0]  key_reg [4];
	logic [63:0]  iv_hi_reg, iv_lo_reg;
	logic         long_reg, dir_reg;
	logic [127:0] chain;
	logic [31:0]  sched [60];
	logic         sched_valid;
	int           nrounds;
	logic [127:0] cipher_q [$];
	logic [7:0]   fwd_box [256];
	logic [7:0]   inv_box [256];

	function automatic logic [7:0] gf_twice(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = gf_twice(a);
		end
		return acc;
	endfunction

	function automatic logic [7:0] gf_recip(input logic [7:0] x);
		logic [7:0] acc, sq;
		acc = 8'h01;
		sq = x;
		for (int i = 0; i < 7; i++) begin
			sq = gf_prod(sq, sq);
			acc = gf_prod(acc, sq);
		end
		return (x == 8'h00) ? 8'h00 : acc;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	initial begin
		logic [7:0] b;
		for (int i = 0; i < 256; i++) begin
			b = gf_recip(8'(i));
			fwd_box[i] = b ^ rot8(b, 1) ^ rot8(b, 2) ^ rot8(b, 3) ^ rot8(b, 4) ^ 8'h63;
			b = 8'(i);
			inv_box[i] = gf_recip(rot8(b, 1) ^ rot8(b, 3) ^ rot8(b, 6) ^ 8'h05);
		end
	end

	function automatic logic [127:0] round_key(input int r);
		return {sched[4*r], sched[4*r+1], sched[4*r+2], sched[4*r+3]};
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
		for (int k = 0; k < 16; k++)
			s[127-8*k -: 8] = inv ? inv_box[s[127-8*k -: 8]] : fwd_box[s[127-8*k -: 8]];
		return s;
	endfunction

	function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		int src, dst;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				src = inv ? r + 4*c : r + 4*((c + r) % 4);
				dst = inv ? r + 4*((c + r) % 4) : r + 4*c;
				t[127-8*dst -: 8] = s[127-8*src -: 8];
			end
		return t;
	endfunction

	function automatic logic [127:0] col_mix(input logic [127:0] s, input logic inv);
		logic [7:0]   m [4];
		logic [7:0]   acc;
		logic [127:0] t;
		if (inv) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
		else m = '{8'h02, 8'h03, 8'h01, 8'h01};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int j = 0; j < 4; j++)
					acc ^= gf_prod(m[(j - r + 4) % 4], s[127-8*(4*c+j) -: 8]);
				t[127-8*(4*c+r) -: 8] = acc;
			end
		return t;
	endfunction

	function automatic logic [127:0] aes_forward(input logic [127:0] s);
		s ^= round_key(0);
		for (int r = 1; r <= nrounds; r++) begin
			s = row_shift(sub_bytes(s, 1'b0), 1'b0);
			if (r < nrounds) s = col_mix(s, 1'b0);
			s ^= round_key(r);
		end
		return s;
	endfunction

	function automatic logic [127:0] aes_inverse(input logic [127:0] s);
		s ^= round_key(nrounds);
		for (int r = nrounds; r > 0; r--) begin
			s = sub_bytes(row_shift(s, 1'b1), 1'b1);
			s ^= round_key(r - 1);
			if (r > 1) s = col_mix(s, 1'b1);
		end
		return s;
	endfunction

	task automatic expand_schedule();
		int nk, total;
		logic [31:0] t;
		logic [7:0]  rc;
		nk = long_reg ? 8 : 4;
		total = 4 * (nk + 7);
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			sched[i] = (i % 2) ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i-1];
			if (i % nk == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
				t[31:24] ^= rc;
				rc = gf_twice(rc);
			end else if (nk == 8 && i % nk == 4) begin
				t = {fwd_box[t[31:24]], fwd_box[t[23:16]], fwd_box[t[15:8]], fwd_box[t[7:0]]};
			end
			sched[i] = sched[i-nk] ^ t;
		end
		nrounds = nk + 6;
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
		errors++;
	endtask

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] blk, res, exp;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_reg[i] = '0;
			iv_hi_reg = '0;
			iv_lo_reg = '0;
			long_reg = 1'b0;
			dir_reg = 1'b0;
			chain = '0;
			sched_valid = 1'b0;
			nrounds = 10;
			cipher_q.delete();
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					report("unexpected transaction, high", result_high, 64'h0);
				end else begin
					exp = cipher_q.pop_front();
					if (result_high !== exp[127:64]) report("result_high", result_high, exp[127:64]);
					if (result_low !== exp[63:0]) report("result_low", result_low, exp[63:0]);
				end
			end
			if (valid && ready) begin
				if (message_start || !sched_valid) begin
					expand_schedule();
					chain = {iv_hi_reg, iv_lo_reg};
					sched_valid = 1'b1;
				end
				blk = {block_high, block_low};
				if (!dir_reg) begin
					res = aes_forward(blk ^ chain);
					chain = res;
				end else begin
					res = aes_inverse(blk) ^ chain;
					chain = blk;
				end
				cipher_q.push_back(res);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					aes_pkg::REG_KEY0: key_reg[0] = pwdata;
					aes_pkg::REG_KEY1: key_reg[1] = pwdata;
					aes_pkg::REG_KEY2: key_reg[2] = pwdata;
					aes_pkg::REG_KEY3: key_reg[3] = pwdata;
					aes_pkg::REG_IVH: iv_hi_reg = pwdata;
					aes_pkg::REG_IVL: iv_lo_reg = pwdata;
					aes_pkg::REG_LONG: long_reg = pwdata[0];
					aes_pkg::REG_DIR: dir_reg = pwdata[0];
					default: ;
				endcase
			end
		end
	end
endmodule

### bench/tb.sv
// Testbench top for the AES-CBC block cipher: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SETTLE = 200;

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [aes_pkg::PADDR_W-1:0] paddr;
	logic [63:0] pwdata, prdata;
	logic valid, ready, message_start, out_valid, out_ready;
	logic [63:0] block_high, block_low, result_high, result_low;
	int errors, pending;
	int idle_pct, stall_pct, hold_req, cycles;

	aes_cbc_block_cipher dut (.*);
	aes_cbc_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** aes_cbc_block_cipher: FAILED **");
			$finish;
		end
	end

	initial begin
		int seen, hold_cnt;
		seen = 0;
		hold_cnt = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != seen) begin
				seen = hold_req;
				hold_cnt = 400;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64(input int mode);
		if (mode == 0) return '0;
		if (mode == 1) return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic configure(input int mode, input logic lk, input logic dir);
		reg_write(aes_pkg::REG_KEY0, rand64(mode));
		reg_write(aes_pkg::REG_KEY1, rand64(mode));
		reg_write(aes_pkg::REG_KEY2, rand64(mode));
		reg_write(aes_pkg::REG_KEY3, rand64(mode));
		reg_write(aes_pkg::REG_IVH, rand64(mode));
		reg_write(aes_pkg::REG_IVL, rand64(mode));
		reg_write(aes_pkg::REG_LONG, {63'b0, lk});
		reg_write(aes_pkg::REG_DIR, {63'b0, dir});
	endtask

	task automatic offer(input logic [63:0] hi, input logic [63:0] lo, input logic st);
		@(negedge clk);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		valid <= 1'b1;
		block_high <= hi;
		block_low <= lo;
		message_start <= st;
		do @(posedge clk); while (!ready);
	endtask

	task automatic stop_offering();
		@(negedge clk);
		valid <= 1'b0;
	endtask

	initial begin
		int idle_set [4];
		int stall_set [4];
		hold_req = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		valid = 1'b0;
		block_high = '0;
		block_low = '0;
		message_start = 1'b0;
		idle_set = '{0, 85, 0, 17};
		stall_set = '{0, 0, 85, 17};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: first transaction after reset without start flag, reset config
		offer('0, '0, 1'b0);
		offer('1, '1, 1'b0);
		offer('0, '1, 1'b1);
		stop_offering();
		drain();
		configure(1, 1'b0, 1'b0);
		offer('1, '1, 1'b1);
		offer('0, '0, 1'b0);
		stop_offering();
		drain();
		configure(1, 1'b1, 1'b1);
		offer('1, '1, 1'b0);
		offer('1, '1, 1'b1);
		offer('0, '0, 1'b0);
		stop_offering();
		drain();
		configure(2, 1'b1, 1'b0);
		offer(rand64(2), rand64(2), 1'b1);
		offer(rand64(2), rand64(2), 1'b0);
		stop_offering();
		drain();
		// direction change mid-message, key change without restart
		reg_write(aes_pkg::REG_DIR, 64'd1);
		reg_write(aes_pkg::REG_KEY0, rand64(2));
		reg_write(aes_pkg::REG_LONG, 64'd0);
		offer(rand64(2), rand64(2), 1'b0);
		offer(rand64(2), rand64(2), 1'b1);
		offer(rand64(2), rand64(2), 1'b0);
		stop_offering();
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			idle_pct = idle_set[ph % 4];
			stall_pct = stall_set[ph % 4];
			configure((ph == 5) ? 0 : 2, 1'(ph >> 1), 1'(ph));
			for (int i = 0; i < 75; i++) begin
				if (ph == 0 && i == 20) hold_req++;
				if (ph == 3 && i == 40) begin
					stop_offering();
					drain();
				end
				offer(rand64($urandom_range(99) < 5 ? $urandom_range(1) : 2),
					rand64($urandom_range(99) < 5 ? $urandom_range(1) : 2),
					($urandom_range(7) == 0));
			end
			stop_offering();
			drain();
		end

		if (errors == 0) begin
			$display("** aes_cbc_block_cipher: PASSED **");
		end else begin
			$display("** aes_cbc_block_cipher: FAILED **");
		end
		$finish;
	end
endmodule
